@@ src/pdf_pkg.sv @@
// Shared types, constants and CRC helper for the packet deframer.
`default_nettype none
package pdf_pkg;

  localparam int MAX_PAYLOAD_BYTES = 512;

  localparam logic [31:0] MAGIC_WORD = 32'h55AA55AA;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

  localparam logic [9:0] LIMIT_CAP         = 10'(MAX_PAYLOAD_BYTES);
  localparam logic [9:0] MAX_PAYLOAD_RESET = 10'd512;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_BAD_CRC  = 2'd2;
  localparam logic [1:0] KIND_TOO_LONG = 2'd3;

  localparam logic [7:0] TYPE_A = 8'h01;
  localparam logic [7:0] TYPE_B = 8'h02;
  localparam logic [7:0] TYPE_C = 8'h03;
  localparam logic [7:0] TYPE_D = 8'h81;
  localparam logic [7:0] TYPE_E = 8'h82;

  localparam logic [9:0] HDR_SEQ_BYTES = 10'd4;
  localparam logic [9:0] HDR_TYPE_IDX  = 10'd4;
  localparam logic [9:0] HDR_LEN_LO    = 10'd5;
  localparam logic [9:0] HDR_LAST_IDX  = 10'd6;
  localparam logic [9:0] CRC_LAST_IDX  = 10'd3;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] seq_number;
    logic [7:0]  packet_type;
    logic [9:0]  payload_length;
  } result_t;

  // Reflected CRC-32, one byte, bit at a time.
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic type_known(input logic [7:0] t);
    return t inside {TYPE_A, TYPE_B, TYPE_C, TYPE_D, TYPE_E};
  endfunction

  // CRC register once the four magic bytes are folded in.
  localparam logic [31:0] CRC_AFTER_MAGIC =
    crc_feed(crc_feed(crc_feed(crc_feed(CRC_INIT, 8'h55), 8'hAA), 8'h55), 8'hAA);

endpackage
`default_nettype wire

@@ src/packet_deframer_crc32.sv @@
// Byte-serial packet deframer with magic sync and CRC-32 check.
// An accepted byte goes to the input register, then its result to the output register.
// Throughput: one byte per cycle unless the output stalls; the byte-wide CRC
// update and header capture are combinational between input and result register.
// Reset (rst, synchronous): hunting, window and counters cleared, CRC all ones,
// max_payload back to 512; no clearing pass.
`default_nettype none
module packet_deframer_crc32 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [31:0]      seq_number,
  output logic [7:0]       packet_type,
  output logic [9:0]       payload_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  cfg_data
);
  import pdf_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic [9:0] max_payload;
  logic       can_load, advance, in_take;
  logic       res_valid;
  result_t    res, res_q;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && can_load;
  assign in_stall  = s1_valid && !can_load;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= rx_byte;
    end
  end

  pdf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .b           (s1_byte),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  pdf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .din       (res),
    .out_stall (out_stall),
    .can_load  (can_load),
    .out_valid (out_valid),
    .dout      (res_q)
  );

  assign kind           = res_q.kind;
  assign data_byte      = res_q.data_byte;
  assign seq_number     = res_q.seq_number;
  assign packet_type    = res_q.packet_type;
  assign payload_length = res_q.payload_length;

endmodule
`default_nettype wire

@@ src/pdf_core.sv @@
// Deframer state machine: magic hunt, header capture, payload, CRC check.
`default_nettype none
module pdf_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       b,
  input  wire logic [9:0]       max_payload,
  output logic                  res_valid,
  output pdf_pkg::result_t      res
);
  import pdf_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] hunt_window, hunt_window_next;
  logic [9:0]  byte_count, byte_count_next;
  logic [31:0] seq_reg, seq_reg_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] received_crc, received_crc_next;

  logic [31:0] win_shift;
  logic [31:0] crc_upd;
  logic [9:0]  cnt_inc;
  logic [31:0] cap_seq;
  logic [7:0]  cap_type;
  logic [15:0] cap_len;
  logic [31:0] cap_rcrc;
  logic [9:0]  limit;
  logic        magic_hit, hdr_done, type_ok, too_long, pay_last, crc_done;

  assign win_shift = {hunt_window[23:0], b};
  assign crc_upd   = crc_feed(running_crc, b);
  assign cnt_inc   = byte_count + 10'd1;
  assign magic_hit = (win_shift == MAGIC_WORD);
  assign limit     = (max_payload < LIMIT_CAP) ? max_payload : LIMIT_CAP;

  // header field capture, valid only in the header phase
  always_comb begin
    cap_seq  = seq_reg;
    cap_type = type_reg;
    cap_len  = length_reg;
    if (phase == PH_HEADER) begin
      if (byte_count < HDR_SEQ_BYTES) begin
        cap_seq = seq_reg | ({24'h0, b} << {byte_count[1:0], 3'b000});
      end else if (byte_count == HDR_TYPE_IDX) begin
        cap_type = b;
      end else if (byte_count == HDR_LEN_LO) begin
        cap_len = {8'h00, b};
      end else begin
        cap_len = length_reg | {b, 8'h00};
      end
    end
  end

  assign cap_rcrc = received_crc | ({24'h0, b} << {byte_count[1:0], 3'b000});
  assign hdr_done = (byte_count == HDR_LAST_IDX);
  assign type_ok  = type_known(cap_type);
  assign too_long = (cap_len > {6'h00, limit});
  assign pay_last = ({6'h00, cnt_inc} >= length_reg);
  assign crc_done = (byte_count[1:0] == CRC_LAST_IDX[1:0]);

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT: begin
        if (magic_hit) phase_next = PH_HEADER;
      end
      PH_HEADER: begin
        if (hdr_done) begin
          if (!type_ok) begin
            phase_next = magic_hit ? PH_HEADER : PH_HUNT;
          end else if (too_long) begin
            phase_next = PH_HUNT;
          end else begin
            phase_next = (cap_len == 16'h0) ? PH_CRC : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (pay_last) phase_next = PH_CRC;
      end
      PH_CRC: begin
        if (crc_done) phase_next = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // datapath and result
  always_comb begin
    hunt_window_next  = hunt_window;
    byte_count_next   = byte_count;
    seq_reg_next      = seq_reg;
    type_reg_next     = type_reg;
    length_reg_next   = length_reg;
    running_crc_next  = running_crc;
    received_crc_next = received_crc;
    res_valid         = 1'b0;
    res.kind          = KIND_DATA;
    res.data_byte     = 8'h00;
    res.seq_number    = cap_seq;
    res.packet_type   = cap_type;
    res.payload_length = (|cap_len[15:10]) ? 10'h3FF : cap_len[9:0];
    case (phase)
      PH_HUNT: begin
        hunt_window_next = win_shift;
        if (magic_hit) begin
          running_crc_next  = CRC_AFTER_MAGIC;
          byte_count_next   = 10'd0;
          seq_reg_next      = 32'h0;
          type_reg_next     = 8'h00;
          length_reg_next   = 16'h0;
          received_crc_next = 32'h0;
        end
      end
      PH_HEADER: begin
        hunt_window_next = win_shift;
        running_crc_next = crc_upd;
        seq_reg_next     = cap_seq;
        type_reg_next    = cap_type;
        length_reg_next  = cap_len;
        byte_count_next  = cnt_inc;
        if (hdr_done) begin
          if (!type_ok) begin
            byte_count_next = 10'd0;
            // window may already hold a fresh magic
            if (magic_hit) begin
              running_crc_next  = CRC_AFTER_MAGIC;
              seq_reg_next      = 32'h0;
              type_reg_next     = 8'h00;
              length_reg_next   = 16'h0;
              received_crc_next = 32'h0;
            end
          end else if (too_long) begin
            res_valid        = 1'b1;
            res.kind         = KIND_TOO_LONG;
            byte_count_next  = 10'd0;
            hunt_window_next = 32'h0;
          end else begin
            byte_count_next = 10'd0;
          end
        end
      end
      PH_PAYLOAD: begin
        running_crc_next = crc_upd;
        byte_count_next  = pay_last ? 10'd0 : cnt_inc;
        res_valid        = 1'b1;
        res.kind         = KIND_DATA;
        res.data_byte    = b;
      end
      PH_CRC: begin
        received_crc_next = cap_rcrc;
        byte_count_next   = cnt_inc;
        if (crc_done) begin
          res_valid        = 1'b1;
          res.kind         = ((running_crc ^ CRC_INIT) == cap_rcrc) ? KIND_GOOD : KIND_BAD_CRC;
          byte_count_next  = 10'd0;
          hunt_window_next = 32'h0;
        end
      end
      default: begin
        byte_count_next  = 10'd0;
        hunt_window_next = 32'h0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      hunt_window  <= 32'h0;
      byte_count   <= 10'd0;
      seq_reg      <= 32'h0;
      type_reg     <= 8'h00;
      length_reg   <= 16'h0;
      running_crc  <= CRC_INIT;
      received_crc <= 32'h0;
    end else if (step) begin
      phase        <= phase_next;
      hunt_window  <= hunt_window_next;
      byte_count   <= byte_count_next;
      seq_reg      <= seq_reg_next;
      type_reg     <= type_reg_next;
      length_reg   <= length_reg_next;
      running_crc  <= running_crc_next;
      received_crc <= received_crc_next;
    end
  end

endmodule
`default_nettype wire

@@ src/pdf_out_reg.sv @@
// Result register on the output channel.
`default_nettype none
module pdf_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire pdf_pkg::result_t din,
  input  wire logic             out_stall,
  output logic                  can_load,
  output logic                  out_valid,
  output pdf_pkg::result_t      dout
);
  import pdf_pkg::*;

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      dout <= din;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/packet_deframer_crc32_test.sv @@
// Self-checking testbench for the packet deframer: framed byte traffic against a scoreboard.
`timescale 1ns / 100ps
module packet_deframer_crc32_test;
  import pdf_pkg::*;

  localparam logic [31:0] SYNC_WORD   = 32'h55AA_55AA;
  localparam logic [31:0] CRC32_POLY  = 32'hEDB8_8320;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [7:0]  KNOWN_TYPES [5] = '{TYPE_A, TYPE_B, TYPE_C, TYPE_D, TYPE_E};
  localparam logic [9:0]  CAP_SETTINGS [6] = '{10'd0, 10'd1023, 10'd7, 10'd1, 10'd40, 10'd512};
  // two bytes that would complete a magic, then a header that would emit a payload byte
  localparam logic [7:0]  DECOY [10] = '{8'h55, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00,
                                        TYPE_A, 8'h01, 8'h00, 8'h5A};

  class deframer_sb;
    logic [9:0]  max_payload;
    logic [31:0] window;
    phase_t      phase;
    logic [9:0]  count;
    logic [31:0] seq;
    logic [7:0]  ptype;
    logic [15:0] plen;
    logic [31:0] crc;
    logic [31:0] crc_rx;
    result_t     deframed_due[$];
    int unsigned mismatches;

    function new();
      max_payload = 10'd512;
      window      = '0;
      phase       = PH_HUNT;
      count       = '0;
      seq         = '0;
      ptype       = '0;
      plen        = '0;
      crc         = 32'hFFFF_FFFF;
      crc_rx      = '0;
      mismatches  = 0;
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = (r >> 1) ^ (r[0] ? CRC32_POLY : 32'd0);
      return r;
    endfunction

    static function bit is_known(logic [7:0] t);
      return t == TYPE_A || t == TYPE_B || t == TYPE_C || t == TYPE_D || t == TYPE_E;
    endfunction

    function int payload_cap();
      return (int'(max_payload) < MAX_PAYLOAD_BYTES) ? int'(max_payload) : MAX_PAYLOAD_BYTES;
    endfunction

    function int pending();
      return deframed_due.size();
    endfunction

    function void open_header();
      crc = 32'hFFFF_FFFF;
      for (int i = 3; i >= 0; i--) crc = crc_step(crc, SYNC_WORD[8*i +: 8]);
      phase  = PH_HEADER;
      count  = '0;
      seq    = '0;
      ptype  = '0;
      plen   = '0;
      crc_rx = '0;
    endfunction

    function void push_result(logic [1:0] k, logic [7:0] d);
      result_t r;
      r.kind           = k;
      r.data_byte      = d;
      r.seq_number     = seq;
      r.packet_type    = ptype;
      r.payload_length = (plen > 16'd1023) ? 10'd1023 : plen[9:0];
      deframed_due.push_back(r);
    endfunction

    function void deframe_byte(logic [7:0] b);
      case (phase)
        PH_HUNT: begin
          window = {window[23:0], b};
          if (window == SYNC_WORD) open_header();
        end
        PH_HEADER: begin
          window = {window[23:0], b};
          crc = crc_step(crc, b);
          if (count < 10'd4) seq[8*count +: 8] = b;
          else if (count == 10'd4) ptype = b;
          else if (count == 10'd5) plen = {8'h00, b};
          else plen[15:8] = b;
          count++;
          if (count == 10'd7) begin
            if (!is_known(ptype)) begin
              // window keeps the header tail and may already hold a fresh magic
              phase = PH_HUNT;
              count = '0;
              if (window == SYNC_WORD) open_header();
            end else if (int'(plen) > payload_cap()) begin
              push_result(KIND_TOO_LONG, 8'h00);
              phase  = PH_HUNT;
              count  = '0;
              window = '0;
            end else begin
              count = '0;
              phase = (plen == 16'd0) ? PH_CRC : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          crc = crc_step(crc, b);
          count++;
          push_result(KIND_DATA, b);
          if (16'(count) >= plen) begin
            count = '0;
            phase = PH_CRC;
          end
        end
        PH_CRC: begin
          crc_rx[8*count[1:0] +: 8] = b;
          count++;
          if (count == 10'd4) begin
            push_result(((crc ^ 32'hFFFF_FFFF) == crc_rx) ? KIND_GOOD : KIND_BAD_CRC, 8'h00);
            phase  = PH_HUNT;
            count  = '0;
            window = '0;
          end
        end
        default: begin
          phase  = PH_HUNT;
          count  = '0;
          window = '0;
        end
      endcase
    endfunction

    function void flag(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: expected kind %0d data %02h seq %08h type %02h len %0d", $time, what,
                 want.kind, want.data_byte, want.seq_number, want.packet_type,
                 want.payload_length);
        $display("%0t %s: actual   kind %0d data %02h seq %08h type %02h len %0d", $time, what,
                 got.kind, got.data_byte, got.seq_number, got.packet_type, got.payload_length);
      end
    endfunction

    function void check_deframed(result_t got);
      result_t want;
      if (deframed_due.size() == 0) begin
        flag("unexpected result", '0, got);
        return;
      end
      want = deframed_due.pop_front();
      if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
          got.seq_number !== want.seq_number || got.packet_type !== want.packet_type ||
          got.payload_length !== want.payload_length)
        flag("mismatch", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [31:0] seq_number;
  logic [7:0]  packet_type;
  logic [9:0]  payload_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [9:0]  cfg_data;

  logic [31:0] cycle = '0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  deframer_sb  sb;

  packet_deframer_crc32 u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .data_byte      (data_byte),
    .seq_number     (seq_number),
    .packet_type    (packet_type),
    .payload_length (payload_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_deframed({kind, data_byte, seq_number, packet_type, payload_length});
    if (cycle[6:0] == 7'd0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= (cycle[1:0] != 2'd0);
      default: if ($urandom_range(0, 5) == 0) out_stall <= !out_stall;
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.deframe_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [31:0] header_crc(logic [31:0] sq, logic [7:0] ty, logic [15:0] ln);
    logic [31:0] c;
    logic [7:0]  hdr [7];
    hdr = '{sq[7:0], sq[15:8], sq[23:16], sq[31:24], ty, ln[7:0], ln[15:8]};
    c = 32'hFFFF_FFFF;
    for (int i = 3; i >= 0; i--) c = deframer_sb::crc_step(c, SYNC_WORD[8*i +: 8]);
    foreach (hdr[i]) c = deframer_sb::crc_step(c, hdr[i]);
    return c;
  endfunction

  // with_body off sends the header only (rejected frames)
  task automatic send_frame(input logic [31:0] sq, input logic [7:0] ty, input logic [15:0] ln,
                            input bit with_magic, input bit with_body, input bit bad_crc,
                            input bit magic_body);
    logic [31:0] c;
    logic [7:0]  b;
    c = header_crc(sq, ty, ln);
    if (with_magic)
      for (int i = 3; i >= 0; i--) send_byte(SYNC_WORD[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(sq[8*i +: 8]);
    send_byte(ty);
    send_byte(ln[7:0]);
    send_byte(ln[15:8]);
    if (with_body) begin
      for (int i = 0; i < int'(ln); i++) begin
        b = (magic_body && i < 4) ? SYNC_WORD[8*(3-i) +: 8] : 8'($urandom);
        c = deframer_sb::crc_step(c, b);
        send_byte(b);
      end
      c = ~c;
      if (bad_crc) c = c ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) send_byte(c[8*i +: 8]);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [9:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.max_payload = v;
  endtask

  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int          cap;
    int unsigned k;
    logic [15:0] ln;
    logic [7:0]  ty;
    stop_at = bytes_sent + n_bytes;
    cap = sb.payload_cap();
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      ty = KNOWN_TYPES[$urandom_range(0, 4)];
      if (pick < 70) begin
        if (cap <= 64 && $urandom_range(0, 9) == 0) ln = 16'(cap);
        else ln = 16'($urandom_range(0, (cap < 12) ? cap : 12));
        send_frame($urandom, ty, ln, 1'b1, 1'b1, $urandom_range(0, 4) == 0,
                   $urandom_range(0, 5) == 0);
      end else if (pick < 78) begin
        ln = $urandom_range(0, 1) ? 16'(cap + $urandom_range(1, 3)) : 16'($urandom);
        if (int'(ln) <= cap) ln = 16'(cap + 1);
        send_frame($urandom, ty, ln, 1'b1, 1'b0, 1'b0, 1'b0);
      end else if (pick < 86) begin
        do ty = 8'($urandom); while (deframer_sb::is_known(ty));
        send_frame($urandom, ty, 16'($urandom), 1'b1, 1'b0, 1'b0, 1'b0);
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 6))
          send_byte($urandom_range(0, 1) ? 8'($urandom) : ($urandom_range(0, 1) ? 8'h55 : 8'hAA));
      end else begin
        // magic cut short
        k = $urandom_range(1, 3);
        for (int i = 0; i < int'(k); i++) send_byte(SYNC_WORD[8*(3-i) +: 8]);
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [31:0] tail_seq;
    logic [31:0] c;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    rx_byte   <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_data  <= 10'd0;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // noise, then an overlapping near-magic in front of the first frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_frame(32'h0000_0000, TYPE_A, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_frame(32'hFFFF_FFFF, TYPE_B, 16'd1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_frame(32'h1234_5678, TYPE_C, 16'd2, 1'b1, 1'b1, 1'b1, 1'b0);
    send_frame(32'h8765_4321, TYPE_D, 16'd6, 1'b1, 1'b1, 1'b0, 1'b1);
    send_frame(32'hA5A5_5A5A, TYPE_E, 16'd512, 1'b1, 1'b1, 1'b0, 1'b0);
    send_frame(32'h0000_0001, TYPE_B, 16'd513, 1'b1, 1'b0, 1'b0, 1'b0);
    // unknown type: plain, then one whose header tail is itself a magic
    send_frame(32'h0BAD_0BAD, 8'h7F, 16'd3, 1'b1, 1'b0, 1'b0, 1'b0);
    send_frame(32'h5500_0000, 8'hAA, 16'hAA55, 1'b1, 1'b0, 1'b0, 1'b0);
    send_frame(32'h0102_0304, TYPE_A, 16'd2, 1'b0, 1'b1, 1'b0, 1'b0);
    // oversize length ending in 55 AA: window must be cleared, length saturates
    send_frame(32'hDEAD_BEEF, TYPE_D, 16'hAA55, 1'b1, 1'b0, 1'b0, 1'b0);
    foreach (DECOY[i]) send_byte(DECOY[i]);
    // frame whose CRC ends in 55 AA: CRC bytes must not feed the hunt
    tail_seq = 32'd0;
    c = ~header_crc(tail_seq, TYPE_A, 16'd0);
    while (c[31:16] != 16'hAA55) begin
      tail_seq++;
      c = ~header_crc(tail_seq, TYPE_A, 16'd0);
    end
    send_frame(tail_seq, TYPE_A, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    foreach (DECOY[i]) send_byte(DECOY[i]);

    foreach (CAP_SETTINGS[i]) begin
      settle();
      write_max_payload(CAP_SETTINGS[i]);
      random_traffic(72);
    end
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/pdf_pkg.sv
src/pdf_core.sv
src/pdf_out_reg.sv
src/packet_deframer_crc32.sv
tb/sv/packet_deframer_crc32_test.sv
